### hw/rtl/armm_pkg.sv
// Package for the route-list audio matrix mixer.
// Holds sizes, beat payload types, route entry layout and the Q1.23 output rounding.
// No dependencies; every other file of the block but armm_ram imports it.
package armm_pkg;

	// Table and channel sizes
	localparam int MAX_ROUTES  = 16;
	localparam int NUM_INPUTS  = 4;
	localparam int NUM_OUTPUTS = 4;
	localparam int MIX_FIELDS  = 4;

	// Field widths
	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 16;
	localparam int CH_W     = 3;
	localparam int SLOT_W   = 4;
	localparam int SKIP_W   = 5;
	localparam int ACTIVE_W = 5;
	localparam int PRES_W   = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_ROUTES   = 2'd0,
		CFG_INPUTS_PRESENT  = 2'd1,
		CFG_OUTPUTS_PRESENT = 2'd2
	} cfg_idx_t;

	// Opcodes
	typedef enum logic {
		OP_ROUTE = 1'b0,
		OP_FRAME = 1'b1
	} opcode_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// Derived sizes
	localparam int RADDR_W    = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int RCNT_W     = $clog2(MAX_ROUTES + 1);
	localparam int RCMP_W     = (RCNT_W > ACTIVE_W) ? RCNT_W : ACTIVE_W;
	localparam int CNT_W      = $clog2((1 << CH_W) + 1);
	localparam int IN_SEL_W   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam int OUT_SEL_W  = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
	localparam int PROD_W     = SAMPLE_W + GAIN_W;
	localparam int ACC_W      = PROD_W + $clog2(MAX_ROUTES) + 1;
	localparam int ROUTE_W    = 2 * CH_W + GAIN_W;
	localparam int SKIP_SAT   = (1 << SKIP_W) - 1;
	localparam int RND_SHIFT  = 12;

	// Route table entry
	typedef struct packed {
		logic [CH_W-1:0]          src;
		logic [CH_W-1:0]          dst;
		logic signed [GAIN_W-1:0] gain;
	} route_t;

	// Command beat
	typedef struct packed {
		opcode_t                    opcode;
		logic [SLOT_W-1:0]          route_slot;
		logic [CH_W-1:0]            source_channel;
		logic [CH_W-1:0]            dest_channel;
		logic signed [GAIN_W-1:0]   route_gain;
		logic signed [SAMPLE_W-1:0] sample_0;
		logic signed [SAMPLE_W-1:0] sample_1;
		logic signed [SAMPLE_W-1:0] sample_2;
		logic signed [SAMPLE_W-1:0] sample_3;
	} cmd_t;

	// Mix result beat
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix_0;
		logic signed [SAMPLE_W-1:0] mix_1;
		logic signed [SAMPLE_W-1:0] mix_2;
		logic signed [SAMPLE_W-1:0] mix_3;
		logic [SKIP_W-1:0]          skipped_count;
	} mix_t;

	// Round half up by dropping RND_SHIFT bits, then clamp to Q1.23
	function automatic logic signed [SAMPLE_W-1:0] round_sat(
		input logic signed [ACC_W-1:0] acc
	);
		logic signed [ACC_W:0] biased;
		logic signed [ACC_W:0] shifted;
		logic signed [ACC_W:0] hi;
		logic signed [ACC_W:0] lo;
		biased  = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (RND_SHIFT - 1));
		shifted = biased >>> RND_SHIFT;
		hi      = (ACC_W+1)'((1 << (SAMPLE_W - 1)) - 1);
		lo      = -hi - (ACC_W+1)'(1);
		if (shifted > hi)
			round_sat = hi[SAMPLE_W-1:0];
		else if (shifted < lo)
			round_sat = lo[SAMPLE_W-1:0];
		else
			round_sat = shifted[SAMPLE_W-1:0];
	endfunction

endpackage

### hw/rtl/armm_cmd_if.sv
// Command channel of the mixer: valid/ready handshake with a cmd_t payload.
// Depends on armm_pkg.
interface armm_cmd_if;
	import armm_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/armm_mix_if.sv
// Result channel of the mixer: valid/ready handshake with a mix_t payload.
// Depends on armm_pkg.
interface armm_mix_if;
	import armm_pkg::*;
	logic valid;
	logic ready;
	mix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/audio_route_matrix_mixer_top.sv
// Route-list audio matrix mixer, top level; depends on armm_pkg, the channel interfaces, armm_ram.
// A route beat is taken in idle and leaves the sequencer idle. With n = active_routes capped at 16,
// a frame beat runs n table reads, waits for the MAC pipeline to empty and loads its result once
// the output register is free or being taken (straight from drain when n is 0); the next beat is
// taken once back in idle. The route table's single read port reads one entry per cycle.
// Reset clears control state and the valid bits (every route reads as zero); registers 0, 4, 4.
module audio_route_matrix_mixer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [armm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [armm_pkg::CFG_DATA_W-1:0] cfg_data,
	armm_cmd_if.sink                       cmd,
	armm_mix_if.source                     mix
);
	import armm_pkg::*;

	state_t state_q, state_d;

	// Configuration registers
	logic [ACTIVE_W-1:0] active_routes_q;
	logic [PRES_W-1:0]   inputs_present_q;
	logic [PRES_W-1:0]   outputs_present_q;

	// Effective counts
	logic [RCNT_W-1:0] n_routes;
	logic [CNT_W-1:0]  n_in;
	logic [CNT_W-1:0]  n_out;

	// Control
	logic cmd_acc;
	logic frame_start;
	logic route_wr;
	logic issue;
	logic out_load;

	logic [RCNT_W-1:0]  rd_cnt_q;
	logic [RADDR_W-1:0] rd_addr;
	logic [MAX_ROUTES-1:0] vbits_q;

	// Frame samples
	logic signed [SAMPLE_W-1:0] samp_q [NUM_INPUTS];

	// Pipeline
	logic   pipe_s1_q;
	logic   ent_vld_s1;
	logic [ROUTE_W-1:0] ram_rdata;
	route_t ent;
	logic   skip;
	logic signed [SAMPLE_W-1:0] samp_sel;
	logic signed [PROD_W-1:0]   prod;

	logic   pipe_s2_q;
	logic   mac_s2;
	logic   skip_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic [OUT_SEL_W-1:0]      dst_s2;

	// Accumulators and skip count
	logic signed [ACC_W-1:0] acc_q [NUM_OUTPUTS];
	logic [RCMP_W-1:0]       skip_q;

	// Result register
	logic out_vld_q;
	mix_t out_q;
	logic signed [SAMPLE_W-1:0] mix_arr [MIX_FIELDS];
	logic [SKIP_W-1:0]          skip_out;

	// Clamp the configured counts to the table and channel sizes
	always_comb begin
		if (RCMP_W'(active_routes_q) > RCMP_W'(MAX_ROUTES))
			n_routes = RCNT_W'(MAX_ROUTES);
		else
			n_routes = RCNT_W'(active_routes_q);
		if (CNT_W'(inputs_present_q) > CNT_W'(NUM_INPUTS))
			n_in = CNT_W'(NUM_INPUTS);
		else
			n_in = CNT_W'(inputs_present_q);
		if (CNT_W'(outputs_present_q) > CNT_W'(NUM_OUTPUTS))
			n_out = CNT_W'(NUM_OUTPUTS);
		else
			n_out = CNT_W'(outputs_present_q);
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_routes_q   <= '0;
			inputs_present_q  <= PRES_W'(4);
			outputs_present_q <= PRES_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_ROUTES:   active_routes_q   <= cfg_data[ACTIVE_W-1:0];
				CFG_INPUTS_PRESENT:  inputs_present_q  <= cfg_data[PRES_W-1:0];
				CFG_OUTPUTS_PRESENT: outputs_present_q <= cfg_data[PRES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cmd_acc     = cmd.valid && cmd.ready;
	assign frame_start = cmd_acc && (cmd.data.opcode == OP_FRAME);
	assign route_wr    = cmd_acc && (cmd.data.opcode == OP_ROUTE) &&
		(32'(cmd.data.route_slot) < MAX_ROUTES);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid && cmd.data.opcode == OP_FRAME) begin
					state_d = (n_routes == '0) ? ST_DRAIN : ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (rd_cnt_q + RCNT_W'(1) == n_routes) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_s1_q && !pipe_s2_q && (!out_vld_q || mix.ready)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance the read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
		end else if (frame_start) begin
			rd_cnt_q <= '0;
		end else if (issue) begin
			rd_cnt_q <= rd_cnt_q + RCNT_W'(1);
		end
	end

	assign rd_addr = rd_cnt_q[RADDR_W-1:0];

	// Mark written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q <= '0;
		end else if (route_wr) begin
			vbits_q[RADDR_W'(cmd.data.route_slot)] <= 1'b1;
		end
	end

	armm_ram #(
		.WIDTH (ROUTE_W),
		.DEPTH (MAX_ROUTES)
	) u_route_ram (
		.clk   (clk),
		.we    (route_wr),
		.waddr (RADDR_W'(cmd.data.route_slot)),
		.wdata ({cmd.data.source_channel, cmd.data.dest_channel, cmd.data.route_gain}),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Hold the frame samples
	always_ff @(posedge clk) begin
		if (frame_start) begin
			samp_q[0] <= cmd.data.sample_0;
			if (NUM_INPUTS > 1) samp_q[IN_SEL_W'(1)] <= cmd.data.sample_1;
			if (NUM_INPUTS > 2) samp_q[IN_SEL_W'(2)] <= cmd.data.sample_2;
			if (NUM_INPUTS > 3) samp_q[IN_SEL_W'(3)] <= cmd.data.sample_3;
		end
	end

	// Stage 1 control: read in flight and entry valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1_q  <= 1'b0;
			ent_vld_s1 <= 1'b0;
		end else begin
			pipe_s1_q  <= issue;
			ent_vld_s1 <= vbits_q[rd_addr];
		end
	end

	// Decode the entry, check presence, multiply
	always_comb begin
		ent      = ent_vld_s1 ? route_t'(ram_rdata) : '0;
		skip     = (CNT_W'(ent.src) >= n_in) || (CNT_W'(ent.dst) >= n_out);
		samp_sel = samp_q[ent.src[IN_SEL_W-1:0]];
		prod     = PROD_W'(samp_sel) * PROD_W'(ent.gain);
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s2_q <= 1'b0;
			mac_s2    <= 1'b0;
			skip_s2   <= 1'b0;
		end else begin
			pipe_s2_q <= pipe_s1_q;
			mac_s2    <= pipe_s1_q && !skip;
			skip_s2   <= pipe_s1_q && skip;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		dst_s2  <= ent.dst[OUT_SEL_W-1:0];
	end

	// Accumulate products and count skipped routes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (frame_start) begin
			skip_q <= '0;
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (mac_s2) begin
				acc_q[dst_s2] <= acc_q[dst_s2] + ACC_W'(prod_s2);
			end
			if (skip_s2) begin
				skip_q <= skip_q + RCMP_W'(1);
			end
		end
	end

	// Round, clamp and saturate the skip count
	always_comb begin
		for (int i = 0; i < MIX_FIELDS; i++) begin
			if (i < NUM_OUTPUTS)
				mix_arr[i] = round_sat(acc_q[i]);
			else
				mix_arr[i] = '0;
		end
		if (RCMP_W'(skip_q) > RCMP_W'(SKIP_SAT))
			skip_out = SKIP_W'(SKIP_SAT);
		else
			skip_out = skip_q[SKIP_W-1:0];
	end

	// Result register: load on finish, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (mix.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.mix_0         <= mix_arr[0];
			out_q.mix_1         <= mix_arr[1];
			out_q.mix_2         <= mix_arr[2];
			out_q.mix_3         <= mix_arr[3];
			out_q.skipped_count <= skip_out;
		end
	end

	assign mix.valid = out_vld_q;
	assign mix.data  = out_q;

	// The MAC pipeline is empty whenever a new beat can be taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!pipe_s1_q && !pipe_s2_q))
		else $error("MAC pipeline busy while idle");

	// A frame beat always leaves idle on the next cycle
	a_frame_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame_start |=> (state_q != ST_IDLE))
		else $error("frame beat did not start a pass");

	// Reads never run past the active route count
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rd_cnt_q < n_routes))
		else $error("route read beyond active count");

	// A result is loaded only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || mix.ready))
		else $error("pending result overwritten");

endmodule

### hw/rtl/armm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
module armm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### verif/audio_route_matrix_mixer_top_tb.sv
// Self-checking testbench for audio_route_matrix_mixer_top: drives route and frame beats,
// mirrors the route table and registers, predicts each frame's mixes and skip count.
// Depends on armm_pkg, armm_cmd_if, armm_mix_if and the mixer RTL.
module audio_route_matrix_mixer_top_tb;
	import armm_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int RANDOM_PHASES   = 15;
	localparam int BEATS_PER_PHASE = 100;
	localparam int REPORT_LIMIT    = 10;
	localparam int PRESENT_RESET   = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam longint Q23_MAX = (1 << (SAMPLE_W - 1)) - 1;
	localparam longint Q23_MIN = -Q23_MAX - 1;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
	localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = 16'sh7fff;
	localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = 16'sh8000;
	localparam logic signed [GAIN_W-1:0]   GAIN_HALF  = 16'sh0800;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	armm_cmd_if cmd_ch ();
	armm_mix_if mix_ch ();

	audio_route_matrix_mixer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.mix       (mix_ch)
	);

	// Shadow copy of the route table and registers
	route_t              route_shadow [MAX_ROUTES];
	logic [ACTIVE_W-1:0] active_shadow;
	logic [PRES_W-1:0]   inputs_shadow;
	logic [PRES_W-1:0]   outputs_shadow;

	cmd_t pending_beats [$];
	mix_t mix_expected [$];
	int   presented   = 0;
	int   accepted    = 0;
	int   err_count   = 0;
	int   cycle_count = 0;
	int   gap_left    = 0;
	int   stall_left  = 0;
	bit   cmd_calm    = 1'b0;
	bit   mix_calm    = 1'b0;
	bit   hold_for_drain = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_W'(int'($urandom_range(0, 8192)) - 4096);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [GAIN_W-1:0] rand_gain();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return GAIN_MAX;
			1: return GAIN_MIN;
			2, 3: return GAIN_W'(int'($urandom_range(0, 8192)) - 4096);
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	// Mostly channels that exist, sometimes any channel number
	function automatic logic [CH_W-1:0] rand_channel(int present);
		if ($urandom_range(0, 4) == 0)
			return CH_W'($urandom());
		return CH_W'($urandom_range(0, present - 1));
	endfunction

	// Unused fields of either opcode carry random content as well
	function automatic cmd_t rand_beat();
		cmd_t c;
		c.opcode         = ($urandom_range(0, 3) == 0) ? OP_ROUTE : OP_FRAME;
		c.route_slot     = SLOT_W'($urandom());
		c.source_channel = rand_channel(NUM_INPUTS);
		c.dest_channel   = rand_channel(NUM_OUTPUTS);
		c.route_gain     = rand_gain();
		c.sample_0       = rand_sample();
		c.sample_1       = rand_sample();
		c.sample_2       = rand_sample();
		c.sample_3       = rand_sample();
		return c;
	endfunction

	function automatic cmd_t route_beat(int slot, int src, int dst, logic signed [GAIN_W-1:0] g);
		cmd_t c;
		c                = '0;
		c.opcode         = OP_ROUTE;
		c.route_slot     = SLOT_W'(slot);
		c.source_channel = CH_W'(src);
		c.dest_channel   = CH_W'(dst);
		c.route_gain     = g;
		return c;
	endfunction

	function automatic cmd_t frame_beat(logic signed [SAMPLE_W-1:0] s0,
		logic signed [SAMPLE_W-1:0] s1, logic signed [SAMPLE_W-1:0] s2,
		logic signed [SAMPLE_W-1:0] s3);
		cmd_t c;
		c          = '0;
		c.opcode   = OP_FRAME;
		c.sample_0 = s0;
		c.sample_1 = s1;
		c.sample_2 = s2;
		c.sample_3 = s3;
		return c;
	endfunction

	// Round half up to Q1.23 and clamp
	function automatic logic signed [SAMPLE_W-1:0] sat_q23(longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
		if (q > Q23_MAX)
			q = Q23_MAX;
		else if (q < Q23_MIN)
			q = Q23_MIN;
		return SAMPLE_W'(q);
	endfunction

	// Mix one frame through the active part of the shadow route table
	function automatic mix_t mix_frame(cmd_t c);
		longint samp [1 << CH_W];
		longint acc [1 << CH_W];
		int     n_routes;
		int     n_in;
		int     n_out;
		int     skipped;
		mix_t   m;
		for (int i = 0; i < (1 << CH_W); i++) begin
			samp[i] = 0;
			acc[i]  = 0;
		end
		samp[0]  = longint'($signed(c.sample_0));
		samp[1]  = longint'($signed(c.sample_1));
		samp[2]  = longint'($signed(c.sample_2));
		samp[3]  = longint'($signed(c.sample_3));
		n_routes = (active_shadow > MAX_ROUTES) ? MAX_ROUTES : int'(active_shadow);
		n_in     = (inputs_shadow > NUM_INPUTS) ? NUM_INPUTS : int'(inputs_shadow);
		n_out    = (outputs_shadow > NUM_OUTPUTS) ? NUM_OUTPUTS : int'(outputs_shadow);
		skipped  = 0;
		for (int i = 0; i < n_routes; i++) begin
			if (route_shadow[i].src >= n_in || route_shadow[i].dst >= n_out)
				skipped++;
			else
				acc[route_shadow[i].dst] += samp[route_shadow[i].src] *
					longint'($signed(route_shadow[i].gain));
		end
		m.mix_0         = sat_q23(acc[0]);
		m.mix_1         = sat_q23(acc[1]);
		m.mix_2         = sat_q23(acc[2]);
		m.mix_3         = sat_q23(acc[3]);
		m.skipped_count = SKIP_W'((skipped > SKIP_SAT) ? SKIP_SAT : skipped);
		return m;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			err_count++;
			if (err_count <= REPORT_LIMIT)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Track register writes and beats; check each result against the oldest prediction
	always @(posedge clk) begin : monitor
		mix_t want;
		if (!arst_n) begin
			foreach (route_shadow[i])
				route_shadow[i] = '0;
			active_shadow  = '0;
			inputs_shadow  = PRES_W'(PRESENT_RESET);
			outputs_shadow = PRES_W'(PRESENT_RESET);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACTIVE_ROUTES:   active_shadow  = cfg_data[ACTIVE_W-1:0];
					CFG_INPUTS_PRESENT:  inputs_shadow  = cfg_data[PRES_W-1:0];
					CFG_OUTPUTS_PRESENT: outputs_shadow = cfg_data[PRES_W-1:0];
					default: ;
				endcase
			end
			if (mix_ch.valid && mix_ch.ready) begin
				if (mix_expected.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_LIMIT)
						$display("result beat with no frame pending: %h", mix_ch.data);
				end else begin
					want = mix_expected.pop_front();
					check_field("mix_0", $signed(want.mix_0), $signed(mix_ch.data.mix_0));
					check_field("mix_1", $signed(want.mix_1), $signed(mix_ch.data.mix_1));
					check_field("mix_2", $signed(want.mix_2), $signed(mix_ch.data.mix_2));
					check_field("mix_3", $signed(want.mix_3), $signed(mix_ch.data.mix_3));
					check_field("skipped_count", want.skipped_count,
						mix_ch.data.skipped_count);
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				accepted++;
				if (cmd_ch.data.opcode == OP_FRAME)
					mix_expected.push_back(mix_frame(cmd_ch.data));
				else if (cmd_ch.data.route_slot < MAX_ROUTES)
					route_shadow[cmd_ch.data.route_slot] = '{
						src:  cmd_ch.data.source_channel,
						dst:  cmd_ch.data.dest_channel,
						gain: cmd_ch.data.route_gain
					};
			end
		end
	end

	// Present pending beats; hold an unaccepted beat, idle for random gaps and now and then until all results are in
	always @(negedge clk) begin : cmd_driver
		if (arst_n && !(cmd_ch.valid && accepted != presented)) begin
			if (mix_expected.size() == 0)
				hold_for_drain = 1'b0;
			if (hold_for_drain) begin
				cmd_ch.valid <= 1'b0;
			end else if (gap_left > 0) begin
				cmd_ch.valid <= 1'b0;
				gap_left--;
			end else if (pending_beats.size() != 0) begin
				cmd_ch.data  <= pending_beats.pop_front();
				cmd_ch.valid <= 1'b1;
				presented++;
				if ($urandom_range(0, 63) == 0)
					cmd_calm = !cmd_calm;
				gap_left       = cmd_calm ? 0 : draw_gap();
				hold_for_drain = ($urandom_range(0, 199) == 0);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the result channel at random
	always @(negedge clk) begin : result_sink
		if (stall_left > 0) begin
			mix_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			mix_ch.ready <= 1'b1;
			if ($urandom_range(0, 63) == 0)
				mix_calm = !mix_calm;
			stall_left = mix_calm ? 0 : draw_gap();
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Wait until every beat is taken and every result is in, then let the block go quiet
	task automatic settle();
		while (pending_beats.size() != 0 || accepted != presented || mix_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_config(int act, int inp, int outp);
		write_reg(CFG_ACTIVE_ROUTES, CFG_DATA_W'(act));
		write_reg(CFG_INPUTS_PRESENT, CFG_DATA_W'(inp));
		write_reg(CFG_OUTPUTS_PRESENT, CFG_DATA_W'(outp));
	endtask

	initial begin : stimulus
		int act;
		int inp;
		int outp;
		int r;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_ACTIVE_ROUTES;
		cfg_data     = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		mix_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: no active routes, full-scale frame mixes to silence
		pending_beats.push_back(frame_beat(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
		// Routes at gain extremes, absent channels and a half-unity gain for rounding
		pending_beats.push_back(route_beat(0, 0, 0, GAIN_MAX));
		pending_beats.push_back(route_beat(1, 1, 0, GAIN_MAX));
		pending_beats.push_back(route_beat(2, 2, 1, GAIN_MIN));
		pending_beats.push_back(route_beat(3, 3, 1, GAIN_MIN));
		pending_beats.push_back(route_beat(4, 7, 2, 16'sh1000));
		pending_beats.push_back(route_beat(5, 0, 7, -16'sd1));
		pending_beats.push_back(route_beat(6, 3, 3, GAIN_HALF));
		settle();
		set_config(7, NUM_INPUTS, NUM_OUTPUTS);

		// Saturate both ways, round half up on a single LSB, and silence
		pending_beats.push_back(frame_beat(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
		pending_beats.push_back(frame_beat(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
		pending_beats.push_back(frame_beat('0, '0, '0, 24'sd1));
		pending_beats.push_back(frame_beat('0, '0, '0, -24'sd1));
		pending_beats.push_back(frame_beat('0, '0, '0, '0));
		pending_beats.push_back(route_beat(15, 7, 7, GAIN_MIN));
		settle();

		// Route count and input count above range, no outputs: every route skipped
		set_config((1 << ACTIVE_W) - 1, (1 << CFG_DATA_W) - 1, 0);
		pending_beats.push_back(frame_beat(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));
		settle();

		// No inputs, output count above range
		set_config(MAX_ROUTES, 0, (1 << CFG_DATA_W) - 1);
		pending_beats.push_back(frame_beat(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
		settle();

		// Write to an unused register index must change nothing
		set_config(MAX_ROUTES, NUM_INPUTS, NUM_OUTPUTS);
		write_reg(CFG_UNUSED, '1);
		pending_beats.push_back(frame_beat(SAMPLE_MAX, SAMPLE_MIN, 24'sd1, -24'sd1));
		pending_beats.push_back(rand_beat());

		// Random phases, each under its own register settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			r    = $urandom_range(0, 9);
			act  = (r < 4) ? MAX_ROUTES : (r < 5) ? 0 : (r < 6) ? (1 << ACTIVE_W) - 1 :
				$urandom_range(0, (1 << CFG_DATA_W) - 1);
			inp  = ($urandom_range(0, 9) < 6) ? NUM_INPUTS :
				$urandom_range(0, (1 << CFG_DATA_W) - 1);
			outp = ($urandom_range(0, 9) < 6) ? NUM_OUTPUTS :
				$urandom_range(0, (1 << CFG_DATA_W) - 1);
			set_config(act, inp, outp);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
			for (int k = 0; k < BEATS_PER_PHASE; k++)
				pending_beats.push_back(rand_beat());
		end
		settle();

		if (err_count == 0 && mix_expected.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
